### src/ffha_pkg.sv
// Package with shared constants, types and codes of the first-fit heap allocator.
package ffha_pkg;

    localparam int HEAP_PAGES   = 4;
    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 12;
    localparam int ARENA_BYTES  = HEAP_PAGES * PAGE_BYTES;
    localparam int MIN_SPLIT    = 4;

    localparam int SIZE_W  = $clog2(ARENA_BYTES);
    localparam int OFF_W   = SIZE_W + 2;
    localparam int IDX_W   = SIZE_W - 2;
    localparam int DEPTH   = ARENA_BYTES / 4;
    localparam int PG_W    = $clog2(HEAP_PAGES + 1) > 3 ? $clog2(HEAP_PAGES + 1) : 3;
    localparam int PAGE_SH = $clog2(PAGE_BYTES);
    localparam int NEED_W  = 17;

    localparam int OP_W     = 2;
    localparam int REQ_W    = 16;
    localparam int ADDR_W   = 32;
    localparam int STAT_W   = 2;
    localparam int USED_W   = 15;
    localparam int LIMIT_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_OOM   = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // one header word: free mark and payload size
    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
    } t_hdr;

    typedef enum logic [4:0] {
        DP_NOP, DP_INIT_WR, DP_LOAD, DP_FREE_START, DP_SET_RANGE, DP_SET_OOM,
        DP_READ, DP_READ_N, DP_STEP, DP_HOLD_CUR, DP_GROW_START, DP_GROW_STEP,
        DP_GROW_WR, DP_SPLIT_WR, DP_ALLOC_WR, DP_FREE_CUR, DP_MERGE, DP_FREE_WR,
        DP_SUM_STEP, DP_PUSH
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic at_end;
        logic nxt_end;
        logic word_free;
        logic fits;
        logic split;
        logic grow_ok;
        logic addr_null;
        logic addr_out;
        logic out_free;
    } t_dp_stat;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DISPATCH, S_SRCH_RD, S_SRCH_EV, S_GROW_RD, S_GROW_EV,
        S_GROW_WR, S_ALLOC, S_ALLOC_WR, S_FREE_RD, S_FREE_EV, S_FREE_NRD,
        S_FREE_NEV, S_SUM_RD, S_SUM_EV, S_DONE
    } t_state;

endpackage

### src/ffha_in_if.sv
// Request channel interface of the heap allocator.
interface ffha_in_if import ffha_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] block_address;
    logic              page_grant;

    modport source (output valid, operation, request_bytes, block_address, page_grant,
                    input ready);
    modport sink   (input valid, operation, request_bytes, block_address, page_grant,
                    output ready);
endinterface

### src/ffha_out_if.sv
// Result channel interface of the heap allocator.
interface ffha_out_if import ffha_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] payload_address;
    logic [USED_W-1:0] used_bytes;

    modport source (output valid, status, payload_address, used_bytes, input ready);
    modport sink   (input valid, status, payload_address, used_bytes, output ready);
endinterface

### src/ffha_dp.sv
// Datapath: header memory, walk offset, config, result and output registers.
module ffha_dp import ffha_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [REQ_W-1:0]     i_request_bytes,
    input  logic [ADDR_W-1:0]    i_block_address,
    input  logic                 i_page_grant,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STAT_W-1:0]    o_status,
    output logic [ADDR_W-1:0]    o_payload_address,
    output logic [USED_W-1:0]    o_used_bytes
);

    t_hdr r_mem [DEPTH];
    t_hdr r_rdata;
    t_hdr r_cur;
    t_hdr r_last;
    logic [OFF_W-1:0]   r_o;
    logic [OFF_W-1:0]   r_last_o;
    logic [NEED_W-1:0]  r_need;
    t_op                r_op;
    logic               r_grant;
    logic               r_grown;
    logic [ADDR_W-1:0]  r_addr;
    logic [PG_W-1:0]    r_pages;
    logic [ADDR_W-1:0]  r_base;
    logic [LIMIT_W-1:0] r_limit;
    t_status            r_res_status;
    logic [ADDR_W-1:0]  r_res_payload;
    logic [USED_W-1:0]  r_sum;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status;
    logic [ADDR_W-1:0]  r_payload;
    logic [USED_W-1:0]  r_used;

    logic [OFF_W-1:0]  w_ext;
    logic [OFF_W-1:0]  w_follow;
    logic [OFF_W-1:0]  w_nxt;
    logic [OFF_W-1:0]  w_rem;
    logic [ADDR_W-1:0] w_rel;
    logic [NEED_W-1:0] w_need_in;
    logic              w_split;
    logic [IDX_W-1:0]  w_ridx;
    logic              w_we;
    logic [IDX_W-1:0]  w_widx;
    t_hdr              w_wdata;

    // arena extent and walk arithmetic
    assign w_ext     = OFF_W'(r_pages) << PAGE_SH;
    assign w_follow  = r_o + OFF_W'(HEADER_BYTES) + OFF_W'(r_rdata.size);
    assign w_nxt     = r_o + OFF_W'(HEADER_BYTES) + OFF_W'(r_cur.size);
    assign w_rem     = r_o + OFF_W'(HEADER_BYTES) + OFF_W'(r_need);
    assign w_rel     = r_addr - r_base;
    assign w_need_in = (NEED_W'(i_request_bytes) + NEED_W'(3)) & ~NEED_W'(3);
    assign w_split   = (NEED_W+1)'(r_cur.size) >=
                       (NEED_W+1)'(r_need) + (NEED_W+1)'(HEADER_BYTES + MIN_SPLIT);

    // status toward the controller
    assign o_stat.op        = r_op;
    assign o_stat.at_end    = r_o >= w_ext;
    assign o_stat.nxt_end   = w_nxt >= w_ext;
    assign o_stat.word_free = r_rdata.free;
    assign o_stat.fits      = r_rdata.free && (NEED_W'(r_rdata.size) >= r_need);
    assign o_stat.split     = w_split;
    assign o_stat.grow_ok   = !r_grown && r_grant && (r_pages < PG_W'(r_limit))
                              && (r_pages < PG_W'(HEAP_PAGES));
    assign o_stat.addr_null = r_addr == '0;
    assign o_stat.addr_out  = (w_rel < ADDR_W'(HEADER_BYTES)) || (w_rel >= ADDR_W'(w_ext));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // select read address: walk offset, or the block after the one being freed
    assign w_ridx = (i_cmd == DP_READ_N) ? w_nxt[IDX_W+1:2] : r_o[IDX_W+1:2];

    // select write port
    always_comb begin
        w_we    = 1'b0;
        w_widx  = r_o[IDX_W+1:2];
        w_wdata = r_cur;
        case (i_cmd)
            DP_INIT_WR: begin
                w_we    = 1'b1;
                w_widx  = '0;
                w_wdata = '{free: 1'b1, size: SIZE_W'(PAGE_BYTES - HEADER_BYTES)};
            end
            DP_GROW_WR: begin
                w_we = 1'b1;
                if (r_last.free) begin
                    w_widx  = r_last_o[IDX_W+1:2];
                    w_wdata = '{free: 1'b1, size: r_last.size + SIZE_W'(PAGE_BYTES)};
                end else begin
                    w_widx  = w_ext[IDX_W+1:2];
                    w_wdata = '{free: 1'b1, size: SIZE_W'(PAGE_BYTES - HEADER_BYTES)};
                end
            end
            DP_SPLIT_WR: begin
                w_we    = 1'b1;
                w_widx  = w_rem[IDX_W+1:2];
                w_wdata = '{free: 1'b1,
                            size: r_cur.size - SIZE_W'(r_need) - SIZE_W'(HEADER_BYTES)};
            end
            DP_ALLOC_WR: begin
                w_we    = 1'b1;
                w_wdata = '{free: 1'b0, size: w_split ? SIZE_W'(r_need) : r_cur.size};
            end
            DP_FREE_WR: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // header memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_widx] <= w_wdata;
        end
        r_rdata <= r_mem[w_ridx];
    end

    // walk and item registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_LOAD: begin
                r_op          <= t_op'(i_operation);
                r_need        <= w_need_in;
                r_addr        <= i_block_address;
                r_grant       <= i_page_grant;
                r_o           <= '0;
                r_res_status  <= ST_OK;
                r_res_payload <= '0;
                r_sum         <= '0;
            end
            DP_FREE_START: r_o <= OFF_W'(w_rel - ADDR_W'(HEADER_BYTES));
            DP_SET_RANGE:  r_res_status <= ST_RANGE;
            DP_SET_OOM:    r_res_status <= ST_OOM;
            DP_STEP:       r_o <= w_follow;
            DP_HOLD_CUR:   r_cur <= r_rdata;
            DP_GROW_START: r_o <= '0;
            DP_GROW_STEP: begin
                r_last_o <= r_o;
                r_last   <= r_rdata;
                r_o      <= w_follow;
            end
            DP_GROW_WR:    r_o <= '0;
            DP_ALLOC_WR:   r_res_payload <= r_base + ADDR_W'(r_o) + ADDR_W'(HEADER_BYTES);
            DP_FREE_CUR:   r_cur <= '{free: 1'b1, size: r_rdata.size};
            DP_MERGE:      r_cur.size <= r_cur.size + SIZE_W'(HEADER_BYTES) + r_rdata.size;
            DP_SUM_STEP: begin
                if (!r_rdata.free) begin
                    r_sum <= r_sum + USED_W'(r_rdata.size);
                end
                r_o <= w_follow;
            end
            default: begin
                r_o <= r_o;
            end
        endcase
    end

    // control state: pages, grow mark, config, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages     <= PG_W'(1);
            r_grown     <= 1'b0;
            r_base      <= '0;
            r_limit     <= LIMIT_W'(4);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd == DP_LOAD) begin
                r_grown <= 1'b0;
            end else if (i_cmd == DP_GROW_WR) begin
                r_grown <= 1'b1;
                r_pages <= r_pages + PG_W'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HEAP_BASE:  r_base  <= i_cfg_data;
                    CFG_PAGE_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                    default:        r_base  <= r_base;
                endcase
            end
            if (i_cmd == DP_PUSH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd == DP_PUSH) begin
            r_status  <= r_res_status;
            r_payload <= r_res_payload;
            r_used    <= r_sum;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_payload_address = r_payload;
    assign o_used_bytes      = r_used;

    a_pages_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pages >= PG_W'(1)) && (r_pages <= PG_W'(HEAP_PAGES)))
        else $error("page count out of range");
    a_grow_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_GROW_WR) |-> !r_grown)
        else $error("heap grown twice for one item");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_PUSH) |-> (!r_out_valid || i_out_ready))
        else $error("result overwrites a pending item");

endmodule

### src/ffha_ctrl.sv
// Controller state machine sequencing the allocator datapath.
module ffha_ctrl import ffha_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:     n_state = S_IDLE;
            S_IDLE:     if (i_in_valid) n_state = S_DISPATCH;
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_ALLOC: n_state = S_SRCH_RD;
                    OP_FREE: begin
                        if (i_stat.addr_null || i_stat.addr_out) n_state = S_DONE;
                        else n_state = S_FREE_RD;
                    end
                    OP_QUERY: n_state = S_SUM_RD;
                    default:  n_state = S_DONE;
                endcase
            end
            S_SRCH_RD: begin
                if (!i_stat.at_end) n_state = S_SRCH_EV;
                else if (i_stat.grow_ok) n_state = S_GROW_RD;
                else n_state = S_DONE;
            end
            S_SRCH_EV:  n_state = i_stat.fits ? S_ALLOC : S_SRCH_RD;
            S_GROW_RD:  n_state = i_stat.at_end ? S_GROW_WR : S_GROW_EV;
            S_GROW_EV:  n_state = S_GROW_RD;
            S_GROW_WR:  n_state = S_SRCH_RD;
            S_ALLOC:    n_state = S_ALLOC_WR;
            S_ALLOC_WR: n_state = S_DONE;
            S_FREE_RD:  n_state = S_FREE_EV;
            S_FREE_EV:  n_state = S_FREE_NRD;
            S_FREE_NRD: n_state = i_stat.nxt_end ? S_DONE : S_FREE_NEV;
            S_FREE_NEV: n_state = i_stat.word_free ? S_FREE_NRD : S_DONE;
            S_SUM_RD:   n_state = i_stat.at_end ? S_DONE : S_SUM_EV;
            S_SUM_EV:   n_state = S_SUM_RD;
            S_DONE:     if (i_stat.out_free) n_state = S_IDLE;
            default:    n_state = S_INIT;
        endcase
    end

    // datapath command and handshake
    always_comb begin
        o_cmd      = DP_NOP;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: o_cmd = DP_INIT_WR;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = DP_LOAD;
            end
            S_DISPATCH: begin
                if (i_stat.op == OP_FREE && !i_stat.addr_null) begin
                    o_cmd = i_stat.addr_out ? DP_SET_RANGE : DP_FREE_START;
                end
            end
            S_SRCH_RD: begin
                if (!i_stat.at_end) o_cmd = DP_READ;
                else if (i_stat.grow_ok) o_cmd = DP_GROW_START;
                else o_cmd = DP_SET_OOM;
            end
            S_SRCH_EV:  o_cmd = i_stat.fits ? DP_HOLD_CUR : DP_STEP;
            S_GROW_RD:  if (!i_stat.at_end) o_cmd = DP_READ;
            S_GROW_EV:  o_cmd = DP_GROW_STEP;
            S_GROW_WR:  o_cmd = DP_GROW_WR;
            S_ALLOC:    if (i_stat.split) o_cmd = DP_SPLIT_WR;
            S_ALLOC_WR: o_cmd = DP_ALLOC_WR;
            S_FREE_RD:  o_cmd = DP_READ;
            S_FREE_EV:  o_cmd = DP_FREE_CUR;
            S_FREE_NRD: o_cmd = i_stat.nxt_end ? DP_FREE_WR : DP_READ_N;
            S_FREE_NEV: o_cmd = i_stat.word_free ? DP_MERGE : DP_FREE_WR;
            S_SUM_RD:   if (!i_stat.at_end) o_cmd = DP_READ;
            S_SUM_EV:   o_cmd = DP_SUM_STEP;
            S_DONE:     if (i_stat.out_free) o_cmd = DP_PUSH;
            default:    o_cmd = DP_NOP;
        endcase
    end

    a_init_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_INIT))
        else $error("controller not in init after reset");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> !o_in_ready)
        else $error("second item taken while one is at work");

endmodule

### src/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: controller, datapath and ports.
// Each item is one allocate, free or query. The block works on one item at a
// time; the result waits in an output register, so the next item may enter
// while it is not yet taken. Time per item is set by the walk over the block
// headers in a 4096 x 15 bit header memory with one registered read a cycle.
// Allocate walks the blocks ahead of the fit; when the heap must grow, it adds
// the failed search and the walk to the last block before the second search.
// Free reads its block and, unless that block is the last one, the block after
// it, plus one more read per merged block; query walks every block; null,
// out-of-range free and unused codes end without a walk.
// After reset the block writes the initial free block before it accepts items.
module first_fit_heap_allocator_top import ffha_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ffha_in_if.sink              i_in,
    ffha_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_ready;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    assign i_in.ready = w_ready;

    ffha_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_operation       (i_in.operation),
        .i_request_bytes   (i_in.request_bytes),
        .i_block_address   (i_in.block_address),
        .i_page_grant      (i_in.page_grant),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out.valid),
        .i_out_ready       (o_out.ready),
        .o_status          (o_out.status),
        .o_payload_address (o_out.payload_address),
        .o_used_bytes      (o_out.used_bytes)
    );

endmodule
